FILE: rtl/arabic_contextual_shaper_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Arabic contextual shaper
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ARABIC_CONTEXTUAL_SHAPER_MACROS_SVH
`define ARABIC_CONTEXTUAL_SHAPER_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define ACS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Checked property that also holds during reset.
`define ACS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define ACS_ASSERT(label, clk, rst_n, prop)
`define ACS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// Arabic contextual shaper package
// Shared widths, codes, result types and the presentation form table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acs_pkg;

    // Field widths.
    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int FORM_W  = 16;

    // Default depth of the result queue; it must hold at least two beats.
    localparam int ACS_OUT_DEPTH = 3;

    // Reset value of the code point limit.
    localparam logic [COUNT_W-1:0] MAX_CP_RESET = 16'd1023;

    // UTF-8 lead byte classes.
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // Replacement for a bad lead byte.
    localparam logic [CP_W-1:0] CP_QMARK = 21'h00003F;
    // Hamza: Arabic but never joins to the right.
    localparam logic [CP_W-1:0] CP_HAMZA = 21'h000621;

    // Continuation bytes still expected.
    localparam logic [1:0] REM_NONE = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;
    localparam logic [1:0] REM_3    = 2'd3;

    // One result beat.
    typedef struct packed {
        logic            last;
        logic [CP_W-1:0] code;
    } t_result;

    // One result offered to the queue.
    typedef struct packed {
        logic            valid;
        logic            last;
        logic [CP_W-1:0] code;
    } t_push;

    // Presentation forms of one letter.
    typedef struct packed {
        logic              hit;
        logic              joins;
        logic [FORM_W-1:0] iso;
        logic [FORM_W-1:0] ini;
        logic [FORM_W-1:0] med;
        logic [FORM_W-1:0] fin;
    } t_forms;

    // Letter table lookup; misses return all zero.
    function automatic t_forms lookup_forms(input logic [CP_W-1:0] cp);
        t_forms f;
        f = '0;
        case (cp)
            21'h000621: f = '{1'b1, 1'b0, 16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80};
            21'h000622: f = '{1'b1, 1'b0, 16'hFE81, 16'hFE81, 16'hFE82, 16'hFE82};
            21'h000623: f = '{1'b1, 1'b0, 16'hFE83, 16'hFE83, 16'hFE84, 16'hFE84};
            21'h000624: f = '{1'b1, 1'b0, 16'hFE85, 16'hFE85, 16'hFE86, 16'hFE86};
            21'h000625: f = '{1'b1, 1'b0, 16'hFE87, 16'hFE87, 16'hFE88, 16'hFE88};
            21'h000626: f = '{1'b1, 1'b1, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A};
            21'h000627: f = '{1'b1, 1'b0, 16'hFE8D, 16'hFE8D, 16'hFE8E, 16'hFE8E};
            21'h000628: f = '{1'b1, 1'b1, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90};
            21'h000629: f = '{1'b1, 1'b0, 16'hFE93, 16'hFE93, 16'hFE94, 16'hFE94};
            21'h00062A: f = '{1'b1, 1'b1, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96};
            21'h00062B: f = '{1'b1, 1'b1, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A};
            21'h00062C: f = '{1'b1, 1'b1, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E};
            21'h00062D: f = '{1'b1, 1'b1, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2};
            21'h00062E: f = '{1'b1, 1'b1, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6};
            21'h00062F: f = '{1'b1, 1'b0, 16'hFEA9, 16'hFEA9, 16'hFEAA, 16'hFEAA};
            21'h000630: f = '{1'b1, 1'b0, 16'hFEAB, 16'hFEAB, 16'hFEAC, 16'hFEAC};
            21'h000631: f = '{1'b1, 1'b0, 16'hFEAD, 16'hFEAD, 16'hFEAE, 16'hFEAE};
            21'h000632: f = '{1'b1, 1'b0, 16'hFEAF, 16'hFEAF, 16'hFEB0, 16'hFEB0};
            21'h000633: f = '{1'b1, 1'b1, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2};
            21'h000634: f = '{1'b1, 1'b1, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6};
            21'h000635: f = '{1'b1, 1'b1, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA};
            21'h000636: f = '{1'b1, 1'b1, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE};
            21'h000637: f = '{1'b1, 1'b1, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2};
            21'h000638: f = '{1'b1, 1'b1, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6};
            21'h000639: f = '{1'b1, 1'b1, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA};
            21'h00063A: f = '{1'b1, 1'b1, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE};
            21'h000640: f = '{1'b1, 1'b1, 16'h0640, 16'h0640, 16'h0640, 16'h0640};
            21'h000641: f = '{1'b1, 1'b1, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2};
            21'h000642: f = '{1'b1, 1'b1, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6};
            21'h000643: f = '{1'b1, 1'b1, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA};
            21'h000644: f = '{1'b1, 1'b1, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE};
            21'h000645: f = '{1'b1, 1'b1, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2};
            21'h000646: f = '{1'b1, 1'b1, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6};
            21'h000647: f = '{1'b1, 1'b1, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA};
            21'h000648: f = '{1'b1, 1'b0, 16'hFEED, 16'hFEED, 16'hFEEE, 16'hFEEE};
            21'h000649: f = '{1'b1, 1'b0, 16'hFEEF, 16'hFEEF, 16'hFEF0, 16'hFEF0};
            21'h00064A: f = '{1'b1, 1'b1, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2};
            default:    f = '0;
        endcase
        return f;
    endfunction

    // A code point joins to its left neighbor if it is a joining letter.
    function automatic logic joins_left(input logic [CP_W-1:0] cp);
        t_forms f;
        f = lookup_forms(cp);
        return f.hit & f.joins;
    endfunction

    // A code point other than hamza joins to its right neighbor if it is in an Arabic block.
    function automatic logic joins_right(input logic [CP_W-1:0] cp);
        logic arabic;
        arabic = (cp >= 21'h000600 && cp <= 21'h0006FF) ||
                 (cp >= 21'h00FB50 && cp <= 21'h00FDFF) ||
                 (cp >= 21'h00FE70 && cp <= 21'h00FEFF);
        return arabic && (cp != CP_HAMZA);
    endfunction

    // Pick the contextual form; anything outside the table passes through.
    function automatic logic [CP_W-1:0] shape_code(input logic [CP_W-1:0] cp,
                                                   input logic            prev,
                                                   input logic            next);
        t_forms            f;
        logic [FORM_W-1:0] g;
        f = lookup_forms(cp);
        if (prev && next && f.joins) begin
            g = f.med;
        end else if (prev) begin
            g = f.fin;
        end else if (next && f.joins) begin
            g = f.ini;
        end else begin
            g = f.iso;
        end
        return f.hit ? {{(CP_W-FORM_W){1'b0}}, g} : cp;
    endfunction

endpackage

FILE: rtl/acs_out_queue.sv
// ----------------------------------------------------------------------------
// Shaper result queue
// Small shift queue that takes up to two result beats per cycle and hands
// one beat per cycle to the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arabic_contextual_shaper_macros.svh"

module acs_out_queue #(
    parameter int DEPTH = acs_pkg::ACS_OUT_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  acs_pkg::t_push            i_push_a,
    input  acs_pkg::t_push            i_push_b,
    output logic                      o_room,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [acs_pkg::CP_W-1:0]  o_code,
    output logic                      o_last
);
    import acs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] base;
    t_result          r_slot [DEPTH];
    t_result          n_slot [DEPTH];
    t_push            first;
    logic             second;
    logic             pop;

    // Shift out the head beat, then append the new beats in order.
    always_comb begin
        pop    = (r_cnt != '0) && i_ready;
        base   = r_cnt - CNT_W'(pop);
        first  = i_push_a.valid ? i_push_a : i_push_b;
        second = i_push_a.valid && i_push_b.valid;
        for (int i = 0; i < DEPTH - 1; i++) begin
            n_slot[i] = pop ? r_slot[i + 1] : r_slot[i];
        end
        n_slot[DEPTH - 1] = r_slot[DEPTH - 1];
        for (int i = 0; i < DEPTH; i++) begin
            if (first.valid && (base == CNT_W'(i))) begin
                n_slot[i] = '{first.last, first.code};
            end
            if (second && ((base + CNT_W'(1)) == CNT_W'(i))) begin
                n_slot[i] = '{i_push_b.last, i_push_b.code};
            end
        end
        n_cnt = base + CNT_W'(first.valid) + CNT_W'(second);
    end

    // Fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Queue entries.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_room  = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_code  = r_slot[0].code;
    assign o_last  = r_slot[0].last;

    `ACS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH))
    `ACS_ASSERT(a_push_room, i_clk, i_rst_n,
        (i_push_a.valid || i_push_b.valid) |-> o_room)
    `ACS_ASSERT(a_push_shows, i_clk, i_rst_n,
        ((r_cnt == '0) && (i_push_a.valid || i_push_b.valid)) |=> o_valid)

endmodule

FILE: rtl/arabic_contextual_shaper.sv
// ----------------------------------------------------------------------------
// Arabic contextual shaper
// Decodes a UTF-8 byte stream and replaces Arabic letters with their
// isolated, initial, medial or final presentation forms.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries one text byte per
//   beat, with i_end_of_text set on the final byte. The output channel
//   (o_out_valid / i_out_ready) carries one shaped code point per beat, with
//   o_last_of_text set on the final code point of a text.
//   Each code point is held back until the next one is decoded, since its
//   form depends on the right neighbor; the end of a text flushes it.
//   A byte that completes a code point releases the previous code point
//   through the input register, then the decode and shape logic into the
//   result queue.
//   Throughput: one byte per cycle while the result queue has room. A
//   final byte that both completes a code point and flushes the held one
//   yields two beats; the three-entry result queue absorbs them and the
//   input pauses in that case. When the receiver stalls, the queue fills
//   and o_in_ready drops once fewer than two entries are free; nothing is lost.
//   Reset clears all text state and sets the code point limit to 1023.
//   i_cfg_wr_en writes the limit at once; write it only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arabic_contextual_shaper_macros.svh"

module arabic_contextual_shaper #(
    parameter int OUT_DEPTH = acs_pkg::ACS_OUT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [acs_pkg::COUNT_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [acs_pkg::BYTE_W-1:0]   i_text_byte,
    input  logic                         i_end_of_text,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [acs_pkg::CP_W-1:0]     o_shaped_code,
    output logic                         o_last_of_text
);
    import acs_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eot;

    // Text state.
    logic [COUNT_W-1:0] r_max_cp;
    logic [CP_W-1:0]    r_pend_code,  n_pend_code;
    logic               r_pend_valid, n_pend_valid;
    logic               r_prior_jl,   n_prior_jl;
    logic [CP_W-1:0]    r_asm,        n_asm;
    logic [1:0]         r_rem,        n_rem;
    logic [COUNT_W-1:0] r_count,      n_count;

    logic            fire;
    logic            room;
    logic            have;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] code2;
    logic            valid2;
    logic            prior2;
    t_push           push_a;
    t_push           push_b;

    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    // Input beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // Code point limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cp <= MAX_CP_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_cp <= i_cfg_wr_data;
        end
    end

    // UTF-8 decode, lookahead and shaping for the registered byte.
    always_comb begin
        n_pend_code  = r_pend_code;
        n_pend_valid = r_pend_valid;
        n_prior_jl   = r_prior_jl;
        n_asm        = r_asm;
        n_rem        = r_rem;
        n_count      = r_count;
        have         = 1'b0;
        cp           = '0;
        push_a       = '0;
        push_b       = '0;
        code2        = r_pend_code;
        valid2       = r_pend_valid;
        prior2       = r_prior_jl;

        if (fire) begin
            // Continuation bytes are taken without checking their top bits.
            if (r_rem != REM_NONE) begin
                n_asm = {r_asm[CP_W-7:0], r_in_byte[5:0]};
                n_rem = r_rem - REM_ONE;
                if (r_rem == REM_ONE) begin
                    have = 1'b1;
                    cp   = n_asm;
                end
            end else if (r_count < r_max_cp) begin
                if (!r_in_byte[BYTE_W-1]) begin
                    have = 1'b1;
                    cp   = {{(CP_W-BYTE_W){1'b0}}, r_in_byte};
                end else if ((r_in_byte & LEAD2_MASK) == LEAD2_CODE) begin
                    n_asm = {{(CP_W-5){1'b0}}, r_in_byte[4:0]};
                    n_rem = REM_ONE;
                end else if ((r_in_byte & LEAD3_MASK) == LEAD3_CODE) begin
                    n_asm = {{(CP_W-4){1'b0}}, r_in_byte[3:0]};
                    n_rem = REM_TWO;
                end else if ((r_in_byte & LEAD4_MASK) == LEAD4_CODE) begin
                    n_asm = {{(CP_W-3){1'b0}}, r_in_byte[2:0]};
                    n_rem = REM_3;
                end else begin
                    have = 1'b1;
                    cp   = CP_QMARK;
                end
            end

            // A new code point releases the held one.
            if (have) begin
                n_count      = r_count + COUNT_W'(1);
                push_a.valid = r_pend_valid;
                push_a.last  = 1'b0;
                push_a.code  = shape_code(r_pend_code, r_prior_jl, joins_right(cp));
                if (r_pend_valid) begin
                    prior2 = joins_left(r_pend_code);
                end
                code2  = cp;
                valid2 = 1'b1;
            end
            n_pend_code  = code2;
            n_pend_valid = valid2;
            n_prior_jl   = prior2;

            // End of text flushes the held code point and clears the state.
            if (r_in_eot) begin
                push_b.valid = valid2;
                push_b.last  = 1'b1;
                push_b.code  = shape_code(code2, prior2, 1'b0);
                n_pend_code  = '0;
                n_pend_valid = 1'b0;
                n_prior_jl   = 1'b0;
                n_asm        = '0;
                n_rem        = REM_NONE;
                n_count      = '0;
            end
        end
    end

    // Text state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_code  <= '0;
            r_pend_valid <= 1'b0;
            r_prior_jl   <= 1'b0;
            r_asm        <= '0;
            r_rem        <= REM_NONE;
            r_count      <= '0;
        end else begin
            r_pend_code  <= n_pend_code;
            r_pend_valid <= n_pend_valid;
            r_prior_jl   <= n_prior_jl;
            r_asm        <= n_asm;
            r_rem        <= n_rem;
            r_count      <= n_count;
        end
    end

    // Result queue toward the output channel.
    acs_out_queue #(
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_push_b (push_b),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_code   (o_shaped_code),
        .o_last   (o_last_of_text)
    );

    `ACS_ASSERT(a_eot_clears, i_clk, i_rst_n,
        (fire && r_in_eot) |=> (!r_pend_valid && (r_rem == REM_NONE) && (r_count == '0)))
    `ACS_ASSERT(a_prior_needs_pend, i_clk, i_rst_n, !r_pend_valid |-> !r_prior_jl)
    `ACS_ASSERT(a_in_holds, i_clk, i_rst_n, (r_in_valid && !fire) |=> r_in_valid)

endmodule
